@@ sv/twgl_pkg.sv @@
// twgl_pkg: shared constants, register indexes and arithmetic helpers
// for the trilinear wind grid lookup; no dependencies
`timescale 1ns / 1ps

package twgl_pkg;

    localparam int LAT_POINTS = 16;
    localparam int LON_POINTS = 16;
    localparam int ALT_POINTS = 16;

    localparam int LAT_W = $clog2(LAT_POINTS);
    localparam int LON_W = $clog2(LON_POINTS);
    localparam int ALT_W = $clog2(ALT_POINTS);

    localparam int DEPTH    = 4096;
    localparam int ADDR_W   = 12;
    localparam int SAMPLE_W = 24;
    localparam int ENTRY_W  = 2 * SAMPLE_W;
    localparam int POS_W    = 40;
    localparam int RECIP_W  = 32;
    localparam int COORD_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int CORNERS  = 8;
    localparam int IDX_MAX_W = 8;

    localparam logic [COORD_W-1:0] TOP_LAT = COORD_W'((LAT_POINTS - 1) << FRAC_W);
    localparam logic [COORD_W-1:0] TOP_LON = COORD_W'((LON_POINTS - 1) << FRAC_W);
    localparam logic [COORD_W-1:0] TOP_ALT = COORD_W'((ALT_POINTS - 1) << FRAC_W);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [2:0] {
        REG_LAT_ORIGIN = 3'd0,
        REG_LAT_RECIP  = 3'd1,
        REG_LON_ORIGIN = 3'd2,
        REG_LON_RECIP  = 3'd3,
        REG_ALT_ORIGIN = 3'd4,
        REG_ALT_RECIP  = 3'd5
    } reg_index_t;

    // a + round((b - a) * f / 2^16), halves up
    function automatic sample_t blend(input sample_t a, input sample_t b,
                                      input logic [FRAC_W-1:0] f);
        logic signed [SAMPLE_W:0]   diff;
        logic signed [SAMPLE_W+17:0] prod;
        logic signed [SAMPLE_W+17:0] rnd;
        diff = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
        prod = diff * $signed({1'b0, f});
        rnd  = (prod + (SAMPLE_W+18)'(32768)) >>> FRAC_W;
        return sample_t'(a + rnd[SAMPLE_W-1:0]);
    endfunction

    // flat address modulo table depth
    function automatic logic [ADDR_W-1:0] flat_addr(input logic [IDX_MAX_W-1:0] i,
                                                    input logic [IDX_MAX_W-1:0] j,
                                                    input logic [IDX_MAX_W-1:0] k);
        logic [31:0] t;
        t = (32'(i) * 32'(LON_POINTS) + 32'(j)) * 32'(ALT_POINTS) + 32'(k);
        return t[ADDR_W-1:0];
    endfunction

endpackage

@@ sv/twgl_coord.sv @@
// twgl_coord: three-stage grid coordinate pipeline for one axis
// depends on twgl_pkg
`timescale 1ns / 1ps

module twgl_coord import twgl_pkg::*; (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [POS_W-1:0]   q,
    input  logic signed [POS_W-1:0]   org,
    input  logic [RECIP_W-1:0]        recip,
    input  logic [COORD_W-1:0]        top_coord,
    output logic [COORD_W-1:0]        c
);

    logic signed [POS_W:0]     d;
    logic [POS_W-1:0]          ud_reg;
    logic [POS_W-1:0]          ud_next;
    logic [47:0]               hi_reg;
    logic [55:0]               lo_full;
    logic [31:0]               lo_reg;
    logic [48:0]               sum;
    logic [COORD_W-1:0]        c_reg;
    logic [COORD_W-1:0]        c_next;

    assign d       = {q[POS_W-1], q} - {org[POS_W-1], org};
    assign ud_next = (!d[POS_W] && d != '0) ? d[POS_W-1:0] : '0;
    assign lo_full = ud_reg[23:0] * recip;
    assign sum     = {1'b0, hi_reg} + {17'b0, lo_reg};
    assign c_next  = (sum > {25'b0, top_coord}) ? top_coord : sum[COORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            ud_reg <= ud_next;
            hi_reg <= ud_reg[POS_W-1:24] * recip;
            lo_reg <= lo_full[55:24];
            c_reg  <= c_next;
        end
    end

    assign c = c_reg;

endmodule

@@ sv/trilinear_wind_grid_lookup_top.sv @@
// trilinear_wind_grid_lookup_top: grid store and trilinear interpolation pipeline
// depends on twgl_pkg and twgl_coord
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tuser kind, tdata load and query fields
// m_       out  m_tvalid/m_tready   tdata interpolated north/east
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item per cycle unless m_ stalls; a query passes the coordinate, corner address, table read and blend registers
// loads write the table in stage 4, in order with query corner reads
// the table is eight copies, one per corner read port
// a stall on m_ freezes the whole pipeline; s_tready follows it
// reset clears valid bits and config registers, not the table
`timescale 1ns / 1ps

module trilinear_wind_grid_lookup_top import twgl_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, north_sample, east_sample, query_lat, query_lon, query_alt
    input  logic [183:0] s_tdata,
    // kind
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // wind_north_out, wind_east_out
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [39:0]  cfg_data
);

    logic signed [POS_W-1:0] lat_org_reg, lon_org_reg, alt_org_reg;
    logic [RECIP_W-1:0]      lat_rcp_reg, lon_rcp_reg, alt_rcp_reg;

    logic                    en;
    logic [8:1]              qv_reg;
    logic [4:1]              lv_reg;
    logic [ADDR_W-1:0]       ld_idx_reg  [1:4];
    logic [ENTRY_W-1:0]      ld_data_reg [1:4];

    logic [COORD_W-1:0]      c_lat, c_lon, c_alt;
    logic [LAT_W-1:0]        il, ih;
    logic [LON_W-1:0]        jl, jh;
    logic [ALT_W-1:0]        kl, kh;
    logic [FRAC_W-1:0]       fi, fj, fk;

    logic [ADDR_W-1:0]       addr_reg [CORNERS];
    logic [ADDR_W-1:0]       addr_next [CORNERS];
    logic [FRAC_W-1:0]       fi4_reg, fj4_reg, fk4_reg;
    logic [ENTRY_W-1:0]      rd_reg [CORNERS];
    logic [FRAC_W-1:0]       fi5_reg, fj5_reg, fk5_reg;
    sample_t                 n6_reg [4];
    sample_t                 e6_reg [4];
    logic [FRAC_W-1:0]       fj6_reg, fk6_reg;
    sample_t                 n7_reg [2];
    sample_t                 e7_reg [2];
    logic [FRAC_W-1:0]       fk7_reg;
    sample_t                 n8_reg, e8_reg;

    assign en        = !qv_reg[8] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_org_reg <= '0;
            lon_org_reg <= '0;
            alt_org_reg <= '0;
            lat_rcp_reg <= RECIP_W'(16777216);
            lon_rcp_reg <= RECIP_W'(16777216);
            alt_rcp_reg <= RECIP_W'(16777216);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LAT_ORIGIN: lat_org_reg <= cfg_data;
                REG_LAT_RECIP:  lat_rcp_reg <= cfg_data[RECIP_W-1:0];
                REG_LON_ORIGIN: lon_org_reg <= cfg_data;
                REG_LON_RECIP:  lon_rcp_reg <= cfg_data[RECIP_W-1:0];
                REG_ALT_ORIGIN: alt_org_reg <= cfg_data;
                REG_ALT_RECIP:  alt_rcp_reg <= cfg_data[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qv_reg <= '0;
            lv_reg <= '0;
        end else if (en) begin
            qv_reg <= {qv_reg[7:1], s_tvalid && s_tuser[0]};
            lv_reg <= {lv_reg[3:1], s_tvalid && !s_tuser[0]};
        end
    end

    // load payload travels to the write stage
    always_ff @(posedge aclk) begin
        if (en) begin
            ld_idx_reg[1]  <= s_tdata[11:0];
            ld_data_reg[1] <= {s_tdata[35:12], s_tdata[59:36]};
            for (int s = 2; s <= 4; s++) begin
                ld_idx_reg[s]  <= ld_idx_reg[s-1];
                ld_data_reg[s] <= ld_data_reg[s-1];
            end
        end
    end

    twgl_coord u_lat (
        .aclk(aclk), .en(en), .q(s_tdata[99:60]), .org(lat_org_reg),
        .recip(lat_rcp_reg), .top_coord(TOP_LAT), .c(c_lat)
    );
    twgl_coord u_lon (
        .aclk(aclk), .en(en), .q(s_tdata[139:100]), .org(lon_org_reg),
        .recip(lon_rcp_reg), .top_coord(TOP_LON), .c(c_lon)
    );
    twgl_coord u_alt (
        .aclk(aclk), .en(en), .q(s_tdata[179:140]), .org(alt_org_reg),
        .recip(alt_rcp_reg), .top_coord(TOP_ALT), .c(c_alt)
    );

    assign fi = c_lat[FRAC_W-1:0];
    assign fj = c_lon[FRAC_W-1:0];
    assign fk = c_alt[FRAC_W-1:0];
    assign il = c_lat[FRAC_W+LAT_W-1:FRAC_W];
    assign jl = c_lon[FRAC_W+LON_W-1:FRAC_W];
    assign kl = c_alt[FRAC_W+ALT_W-1:FRAC_W];
    assign ih = (fi != '0) ? il + LAT_W'(1) : il;
    assign jh = (fj != '0) ? jl + LON_W'(1) : jl;
    assign kh = (fk != '0) ? kl + ALT_W'(1) : kl;

    // corner bit 2 = lat hi, bit 1 = lon hi, bit 0 = alt hi
    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            addr_next[c] = flat_addr(IDX_MAX_W'(c[2] ? ih : il),
                                     IDX_MAX_W'(c[1] ? jh : jl),
                                     IDX_MAX_W'(c[0] ? kh : kl));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            addr_reg <= addr_next;
            fi4_reg  <= fi;
            fj4_reg  <= fj;
            fk4_reg  <= fk;
        end
    end

    for (genvar g = 0; g < CORNERS; g++) begin : g_bank
        logic [ENTRY_W-1:0] mem [DEPTH];
        always_ff @(posedge aclk) begin
            if (en && lv_reg[4]) begin
                mem[ld_idx_reg[4]] <= ld_data_reg[4];
            end
            if (en) begin
                rd_reg[g] <= mem[addr_reg[g]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fi5_reg <= fi4_reg;
            fj5_reg <= fj4_reg;
            fk5_reg <= fk4_reg;
            for (int p = 0; p < 4; p++) begin
                n6_reg[p] <= blend(rd_reg[p][47:24], rd_reg[p+4][47:24], fi5_reg);
                e6_reg[p] <= blend(rd_reg[p][23:0], rd_reg[p+4][23:0], fi5_reg);
            end
            fj6_reg <= fj5_reg;
            fk6_reg <= fk5_reg;
            for (int p = 0; p < 2; p++) begin
                n7_reg[p] <= blend(n6_reg[p], n6_reg[p+2], fj6_reg);
                e7_reg[p] <= blend(e6_reg[p], e6_reg[p+2], fj6_reg);
            end
            fk7_reg <= fk6_reg;
            n8_reg  <= blend(n7_reg[0], n7_reg[1], fk7_reg);
            e8_reg  <= blend(e7_reg[0], e7_reg[1], fk7_reg);
        end
    end

    assign m_tvalid = qv_reg[8];
    assign m_tdata  = {e8_reg, n8_reg};

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qv_reg[4] && lv_reg[4]))
        else $error("load and query in the same stage");

    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled without a pending result");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && qv_reg[7]) |=> qv_reg[8])
        else $error("query lost between last stages");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (qv_reg == $past(qv_reg)))
        else $error("pipeline moved during stall");

endmodule
